@@ rtl/core/orl_pkg.sv @@
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types and constants of the orbit radius outer loop: field widths,
// register reset values, register indexes, payload and control structs.
// ----------------------------------------------------------------------------
package orl_pkg;

  // Default depth of the radius change history
  localparam int DERIV_TAPS_DEF = 5;

  // Field widths
  localparam int RAD_W      = 24;  // Q16.8 radius
  localparam int SLOT_W     = 25;  // radius change / radius error
  localparam int GAIN_W     = 16;  // Q0.16 gains and forget factors
  localparam int LIM_W      = 15;  // Q2.14 output limit
  localparam int OUT_W      = 16;  // Q2.14 output
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Rounding shifts
  localparam int FORGET_SHIFT = 16;
  localparam int OUT_SHIFT    = 10;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd983;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd6554;
  localparam logic [GAIN_W-1:0] DER_FORGET_RST = 16'd52429;
  localparam logic [GAIN_W-1:0] PRO_FORGET_RST = 16'd64225;
  localparam logic [LIM_W-1:0]  OUT_LIMIT_RST  = 15'd8192;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_DERIV_GAIN = 3'd1,
    CFG_DER_FORGET = 3'd2,
    CFG_PRO_FORGET = 3'd3,
    CFG_OUT_LIMIT  = 3'd4
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECAY,
    ST_PROD,
    ST_FINISH
  } state_t;

  // Input transfer payload
  typedef struct packed {
    logic signed [RAD_W-1:0] measured_radius;
    logic signed [RAD_W-1:0] reference_radius;
  } in_item_t;

  // Output transfer payload
  typedef struct packed {
    logic signed [OUT_W-1:0] heading_rate_error;
    logic                    saturated;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input item
    logic decay;   // apply forget factors
    logic prod;    // update history, form gain products
    logic finish;  // round, clip, load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_ready;  // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ rtl/core/orl_ctrl.sv @@
// ----------------------------------------------------------------------------
// orl_ctrl
// Sequencer of the outer loop: accepts one item in idle, then steps the
// datapath through decay, product and finish, waiting for output space.
// ----------------------------------------------------------------------------
module orl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output orl_pkg::dp_cmd_t    cmd,
  input  orl_pkg::dp_status_t status
);
  import orl_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECAY;
        end
      end
      ST_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (status.out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An accepted item always starts the decay step
  a_accept_to_decay: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DECAY))
    else $error("accepted item did not enter decay step");

  // A blocked finish waits in place
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !status.out_ready) |=> (state_r == ST_FINISH))
    else $error("finish left without output space");

  // Finish is issued only with output space
  a_finish_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (status.out_ready && state_r == ST_FINISH))
    else $error("finish issued while output register blocked");

endmodule

@@ rtl/core/orl_datapath.sv @@
// ----------------------------------------------------------------------------
// orl_datapath
// Registers, change history, forget-factor and gain multipliers, rounding,
// clipping and the output register of the outer loop.
// ----------------------------------------------------------------------------
module orl_datapath #(
  parameter int DERIV_TAPS = orl_pkg::DERIV_TAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  orl_pkg::in_item_t                  in_data,
  input  orl_pkg::dp_cmd_t                   cmd,
  output orl_pkg::dp_status_t                status,
  input  logic                               cfg_we,
  input  logic [orl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [orl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output orl_pkg::out_item_t                 out_data
);
  import orl_pkg::*;

  localparam int SUM_W  = SLOT_W + $clog2(DERIV_TAPS);
  localparam int MUL_W  = SLOT_W + GAIN_W + 1;
  localparam int PSUM_W = SUM_W + GAIN_W + 1;
  localparam int ACC_W  = PSUM_W + 1;
  localparam int Y_W    = ACC_W - OUT_SHIFT;

  // Round to nearest, ties up, after a Q0.16 product
  function automatic logic signed [SLOT_W-1:0] rnd_forget(
    input logic signed [MUL_W-1:0] p
  );
    logic signed [MUL_W-1:0] q;
    q = p + MUL_W'(1 <<< (FORGET_SHIFT - 1));
    return q[FORGET_SHIFT +: SLOT_W];
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_r, deriv_gain_r, der_forget_r, pro_forget_r;
  logic [LIM_W-1:0]  out_limit_r;

  // Loop state
  logic signed [RAD_W-1:0]  prev_meas_r, prev_ref_r;
  logic signed [SLOT_W-1:0] taps_r [DERIV_TAPS];
  logic signed [SUM_W-1:0]  sum_r;

  // Per-item working registers
  logic signed [SLOT_W-1:0] err_r, new_slot_r;
  logic                     have_prev_r, decay_r;
  logic signed [MUL_W-1:0]  p_err_r;
  logic signed [PSUM_W-1:0] p_sum_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Input selection and differences
  logic signed [RAD_W-1:0]  meas_sel, ref_sel;
  logic signed [SLOT_W-1:0] err_in, diff_in;
  logic                     have_prev_in, zero_diff_in;

  assign meas_sel     = in_data.measured_radius[RAD_W-1] ? prev_meas_r
                                                         : in_data.measured_radius;
  assign ref_sel      = in_data.reference_radius[RAD_W-1] ? prev_ref_r
                                                          : in_data.reference_radius;
  assign err_in       = SLOT_W'(ref_sel) - SLOT_W'(meas_sel);
  assign diff_in      = SLOT_W'(meas_sel) - SLOT_W'(prev_meas_r);
  assign have_prev_in = (prev_meas_r != '0);
  assign zero_diff_in = (meas_sel == prev_meas_r);

  // Forget-factor products
  logic signed [MUL_W-1:0] slot_decay_prod, err_decay_prod;
  assign slot_decay_prod = taps_r[0] * $signed({1'b0, der_forget_r});
  assign err_decay_prod  = err_r * $signed({1'b0, pro_forget_r});

  // History sum with the new change swapped in for the oldest, when a previous measurement exists
  logic signed [SUM_W-1:0]  sum_eff;
  logic signed [PSUM_W-1:0] p_sum_nxt;
  logic signed [MUL_W-1:0]  p_err_nxt;
  assign sum_eff   = have_prev_r ? (sum_r - SUM_W'(taps_r[DERIV_TAPS-1])
                                          + SUM_W'(new_slot_r))
                                 : sum_r;
  assign p_sum_nxt = sum_eff * $signed({1'b0, deriv_gain_r});
  assign p_err_nxt = err_r * $signed({1'b0, prop_gain_r});

  // Combine, round and clip
  logic signed [ACC_W-1:0] acc, acc_rnd;
  logic signed [Y_W-1:0]   y, lim, y_clip;
  logic                    sat;
  assign acc     = ACC_W'(p_sum_r) - ACC_W'(p_err_r);
  assign acc_rnd = acc + ACC_W'(1 <<< (OUT_SHIFT - 1));
  assign y       = acc_rnd[ACC_W-1:OUT_SHIFT];
  assign lim     = Y_W'($signed({1'b0, out_limit_r}));

  always_comb begin
    y_clip = y;
    sat    = 1'b0;
    if (y > lim) begin
      y_clip = lim;
      sat    = 1'b1;
    end else if (y < -lim) begin
      y_clip = -lim;
      sat    = 1'b1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      der_forget_r <= DER_FORGET_RST;
      pro_forget_r <= PRO_FORGET_RST;
      out_limit_r  <= OUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_DER_FORGET: der_forget_r <= cfg_wdata[GAIN_W-1:0];
        CFG_PRO_FORGET: pro_forget_r <= cfg_wdata[GAIN_W-1:0];
        CFG_OUT_LIMIT:  out_limit_r  <= cfg_wdata[LIM_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Previous radii, change history and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_meas_r <= '0;
      prev_ref_r  <= '0;
      sum_r       <= '0;
      for (int i = 0; i < DERIV_TAPS; i++) begin
        taps_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        prev_meas_r <= meas_sel;
        prev_ref_r  <= ref_sel;
      end
      // Shift the newest change in, drop the oldest
      if (cmd.prod && have_prev_r) begin
        taps_r[0] <= new_slot_r;
        for (int i = 1; i < DERIV_TAPS; i++) begin
          taps_r[i] <= taps_r[i-1];
        end
        sum_r <= sum_eff;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      decay_r     <= 1'b0;
    end else if (cmd.load) begin
      have_prev_r <= have_prev_in;
      decay_r     <= have_prev_in && zero_diff_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r      <= err_in;
      new_slot_r <= diff_in;
    end else if (cmd.decay && decay_r) begin
      err_r      <= rnd_forget(err_decay_prod);
      new_slot_r <= rnd_forget(slot_decay_prod);
    end
    if (cmd.prod) begin
      p_sum_r <= p_sum_nxt;
      p_err_r <= p_err_nxt;
    end
  end

  // Output register: load on finish, clear when the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.heading_rate_error <= OUT_W'(y_clip);
      out_data_r.saturated          <= sat;
    end
  end

  assign status.out_ready = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

  // A finish always presents a result next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish did not load the output register");

  // Without a previous measurement the history sum is left alone
  a_no_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.prod && !have_prev_r) |=> $stable(sum_r))
    else $error("history sum changed without a previous measurement");

  // The output register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

@@ rtl/core/orbit_radius_outer_loop.sv @@
// ----------------------------------------------------------------------------
// orbit_radius_outer_loop
// Orbit radius outer loop: radius error and change history to a saturated
// heading rate error command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one measured and one
//   reference radius, signed Q16.8 m; a negative radius is replaced by the
//   last accepted one. Output channel (out_valid / out_stall / out_data)
//   returns one Q2.14 rad/s command and a saturation flag per input item.
//   A transfer happens on a rising edge with valid high and stall low.
//   After an input transfer the sequencer steps one shared datapath through
//   capture, forget-factor decay, gain products and round/clip; the result is
//   loaded into the output register at the finish step, and no new item is
//   taken until that step is done.
//   in_stall is high whenever an item is in work; the next item is taken while
//   a finished result still waits in the output register. If the receiver
//   stalls, the result holds and the following item stops at the finish step.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (prop_gain,
//   deriv_gain, der_forget, pro_forget, out_limit); write only while idle.
//   Reset (rst_n low, synchronous) restores register defaults and clears the
//   previous radii, the change history and both channels' control state.
// ----------------------------------------------------------------------------
module orbit_radius_outer_loop #(
  parameter int DERIV_TAPS = orl_pkg::DERIV_TAPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  orl_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output orl_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [orl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [orl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import orl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  orl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath
  orl_datapath #(
    .DERIV_TAPS (DERIV_TAPS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
